// ===== hdl/kpdc_pkg.sv =====
`timescale 1ns / 1ps

package kpdc_pkg;

    localparam int NUM_KEYS_DEFAULT = 6;

    // Field widths
    localparam int FUNC_W     = 1;
    localparam int LEVEL_W    = 6;
    localparam int KEY_CODE_W = 3;
    localparam int KIND_W     = 2;
    localparam int THR_W      = 15;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_POLL = 1'b1;

    // Press kinds
    localparam logic [KIND_W-1:0] KIND_SHORT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG  = 2'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR  = 2'd1;

    localparam logic [THR_W-1:0] SHORT_THR_RESET = 15'd50;
    localparam logic [THR_W-1:0] LONG_THR_RESET  = 15'd1000;

    // Counter constants
    localparam logic signed [CNT_W-1:0] REPEAT_BACKOFF = 16'sd500;
    localparam logic signed [CNT_W-1:0] COUNT_CEILING  = 16'sd30000;
    localparam logic signed [CNT_W-1:0] TICK_STEP      = 16'sd10;
    localparam logic signed [CNT_W-1:0] SHORT_DONE     = -16'sd1;

    typedef struct packed {
        logic load;
        logic step;
    } kpdc_cmd_t;

    typedef struct packed {
        logic report;
        logic last;
        logic out_busy;
    } kpdc_sts_t;

endpackage

// ===== hdl/kpdc_in_if.sv =====
`timescale 1ns / 1ps

interface kpdc_in_if
    import kpdc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [LEVEL_W-1:0] key_levels;

    modport source (output valid, func, key_levels, input ready);
    modport sink   (input valid, func, key_levels, output ready);
endinterface

// ===== hdl/kpdc_out_if.sv =====
`timescale 1ns / 1ps

interface kpdc_out_if
    import kpdc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [KEY_CODE_W-1:0] key_code;
    logic [KIND_W-1:0]     press_kind;

    modport source (output valid, key_code, press_kind, input ready);
    modport sink   (input valid, key_code, press_kind, output ready);
endinterface

// ===== hdl/kpdc_cfg_if.sv =====
`timescale 1ns / 1ps

interface kpdc_cfg_if
    import kpdc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/kpdc_ctrl.sv =====
`timescale 1ns / 1ps

module kpdc_ctrl
    import kpdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  kpdc_sts_t sts,
    output kpdc_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // hold the key while a report waits for a full output slot
                if (!(sts.report && sts.out_busy))
                begin
                    cmd.step = 1'b1;
                    if (sts.report || sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/kpdc_datapath.sv =====
`timescale 1ns / 1ps

module kpdc_datapath
    import kpdc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FUNC_W-1:0]  func,
    input  logic [LEVEL_W-1:0] key_levels,
    input  kpdc_cmd_t          cmd,
    output kpdc_sts_t          sts,
    kpdc_out_if.source         out_ch,
    kpdc_cfg_if.sink           cfg_ch
);

    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(NUM_KEYS - 1);

    logic signed [CNT_W-1:0] cnt_reg [NUM_KEYS];
    logic signed [CNT_W-1:0] cnt_wr;
    logic                    cnt_we;

    logic [KEY_IDX_W-1:0]  idx_reg, idx_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [NUM_KEYS-1:0]   levels_reg;
    logic [THR_W-1:0]      short_thr_reg, long_thr_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [KEY_CODE_W-1:0] key_code_reg, key_code_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;

    logic signed [CNT_W-1:0] cnt_cur;
    logic signed [CNT_W:0]   cnt_ext, lo_ext, hi_ext;
    logic signed [CNT_W-1:0] repeat_val;
    logic                    key_pressed;
    logic                    report;
    logic [KIND_W-1:0]       kind_cur;

    assign cnt_cur     = cnt_reg[idx_reg];
    assign cnt_ext     = {cnt_cur[CNT_W-1], cnt_cur};
    assign lo_ext      = $signed({2'b00, short_thr_reg});
    assign hi_ext      = $signed({2'b00, long_thr_reg});
    assign repeat_val  = $signed({1'b0, long_thr_reg}) - REPEAT_BACKOFF;
    assign key_pressed = levels_reg[idx_reg];

    always_comb
    begin
        cnt_we   = 1'b0;
        cnt_wr   = cnt_cur;
        report   = 1'b0;
        kind_cur = KIND_SHORT;
        if (func_reg == FUNC_TICK)
        begin
            if (key_pressed)
            begin
                if (cnt_cur == SHORT_DONE)
                begin
                    cnt_we = 1'b1;
                    cnt_wr = '0;
                end
                else if (cnt_cur < COUNT_CEILING)
                begin
                    cnt_we = 1'b1;
                    cnt_wr = cnt_cur + TICK_STEP;
                end
            end
        end
        else if (!key_pressed)
        begin
            if (cnt_ext > lo_ext && cnt_ext < hi_ext)
            begin
                cnt_we   = 1'b1;
                cnt_wr   = SHORT_DONE;
                report   = 1'b1;
                kind_cur = KIND_SHORT;
            end
            else if (cnt_cur > 0)
            begin
                cnt_we = 1'b1;
                cnt_wr = '0;
            end
        end
        else if (cnt_ext > hi_ext)
        begin
            cnt_we   = 1'b1;
            cnt_wr   = repeat_val;
            report   = 1'b1;
            kind_cur = KIND_LONG;
        end
    end

    assign sts.report   = report;
    assign sts.last     = (idx_reg == '0);
    assign sts.out_busy = out_valid_reg && !out_ch.ready;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        key_code_next  = key_code_reg;
        kind_next      = kind_reg;
        if (cmd.load)
        begin
            idx_next = LAST_KEY;
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg - 1'b1;
            if (report)
            begin
                out_valid_next = 1'b1;
                key_code_next  = KEY_CODE_W'(idx_reg);
                kind_next      = kind_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cnt_reg[k] <= '0;
            end
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            short_thr_reg <= SHORT_THR_RESET;
            long_thr_reg  <= LONG_THR_RESET;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cmd.step && cnt_we)
            begin
                cnt_reg[idx_reg] <= cnt_wr;
            end
            if (cfg_ch.valid)
            begin
                case (cfg_ch.index)
                    CFG_SHORT_THR: short_thr_reg <= cfg_ch.data;
                    CFG_LONG_THR:  long_thr_reg  <= cfg_ch.data;
                    default:       ;
                endcase
            end
        end
    end

    // keys past the level field read as released
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            levels_reg <= NUM_KEYS'({{NUM_KEYS{1'b0}}, key_levels});
        end
        key_code_reg <= key_code_next;
        kind_reg     <= kind_next;
    end

    assign cfg_ch.ready      = 1'b1;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.key_code   = key_code_reg;
    assign out_ch.press_kind = kind_reg;

endmodule

// ===== hdl/key_press_duration_classifier_unit.sv =====
`timescale 1ns / 1ps

// Short/long key press classifier with auto-repeat. Each word on in_ch is a
// tick (func 0) or a poll (func 1) with the sampled key levels. The block
// walks the per-key hold counters one key per cycle unless held, from the
// highest key down, after loading each word; a poll stops at the first key
// it reports. A poll that reports drives one word on out_ch from an output
// register, and the next input word is taken while that word waits; the
// scan only holds when a second report finds the output register still full.
// Thresholds are written on cfg_ch (index 0 short, index 1 long); the user
// must write them only while the block is idle; the block does not enforce it.
module key_press_duration_classifier_unit
    import kpdc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    kpdc_in_if.sink      in_ch,
    kpdc_out_if.source   out_ch,
    kpdc_cfg_if.sink     cfg_ch
);

    kpdc_cmd_t cmd;
    kpdc_sts_t sts;

    kpdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kpdc_datapath #(
        .NUM_KEYS (NUM_KEYS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (in_ch.func),
        .key_levels (in_ch.key_levels),
        .cmd        (cmd),
        .sts        (sts),
        .out_ch     (out_ch),
        .cfg_ch     (cfg_ch)
    );

endmodule

// ===== sim/key_press_duration_classifier_unit_test.sv =====
`timescale 1ns / 1ps

module key_press_duration_classifier_unit_test;
    import kpdc_pkg::*;

    localparam int NUM_KEYS     = NUM_KEYS_DEFAULT;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE       = 16;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic [KEY_CODE_W-1:0] key_code;
        logic [KIND_W-1:0]     press_kind;
    } key_event_t;

    class press_scoreboard;
        logic signed [CNT_W-1:0] hold_count [NUM_KEYS] = '{default: '0};
        logic [THR_W-1:0]        short_thr = SHORT_THR_RESET;
        logic [THR_W-1:0]        long_thr  = LONG_THR_RESET;
        key_event_t              pending [$];
        int                      errors = 0;

        function void write_threshold(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
            if (idx == CFG_SHORT_THR)
                short_thr = val;
            else if (idx == CFG_LONG_THR)
                long_thr = val;
        endfunction

        function void note_word(logic [FUNC_W-1:0] f, logic [LEVEL_W-1:0] lv);
            int         lo;
            int         hi;
            int         c;
            key_event_t ev;
            lo = short_thr;
            hi = long_thr;
            for (int k = NUM_KEYS - 1; k >= 0; k--)
            begin
                c = hold_count[k];
                if (f == FUNC_TICK)
                begin
                    if (lv[k])
                    begin
                        if (hold_count[k] == SHORT_DONE)
                            hold_count[k] = '0;
                        else if (hold_count[k] < COUNT_CEILING)
                            hold_count[k] = hold_count[k] + TICK_STEP;
                    end
                end
                else if (!lv[k])
                begin
                    if (c > lo && c < hi)
                    begin
                        hold_count[k] = SHORT_DONE;
                        ev.key_code   = KEY_CODE_W'(k);
                        ev.press_kind = KIND_SHORT;
                        pending.push_back(ev);
                        return;
                    end
                    if (c > 0)
                        hold_count[k] = '0;
                end
                else if (c > hi)
                begin
                    // set back so a held key repeats
                    hold_count[k] = CNT_W'(hi - REPEAT_BACKOFF);
                    ev.key_code   = KEY_CODE_W'(k);
                    ev.press_kind = KIND_LONG;
                    pending.push_back(ev);
                    return;
                end
            end
        endfunction

        function void check_result(logic [KEY_CODE_W-1:0] code, logic [KIND_W-1:0] kind);
            key_event_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected word: key_code %0d press_kind %0d", code, kind);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (code !== want.key_code)
            begin
                $error("key_code mismatch: expected %0d, actual %0d", want.key_code, code);
                errors++;
            end
            if (kind !== want.press_kind)
            begin
                $error("press_kind mismatch: expected %0d, actual %0d", want.press_kind, kind);
                errors++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kpdc_in_if  in_ch ();
    kpdc_out_if out_ch ();
    kpdc_cfg_if cfg_ch ();

    press_scoreboard    sb = new();
    bit                 idle_on = 1'b1;
    int                 stall_asks = 0;
    int                 stall_done = 0;
    int                 quiet_cycles = 0;
    logic [LEVEL_W-1:0] held = '0;
    int                 hold_left [NUM_KEYS] = '{default: 0};

    key_press_duration_classifier_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #2 clk = ~clk;

    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [LEVEL_W-1:0] lv);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= f;
        in_ch.key_levels <= lv;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait out pending events, then the scan of a trailing tick
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // keys follow press/release runs of random length; a few words carry noise levels
    task automatic run_phase(input logic [THR_W-1:0] short_val, input logic [THR_W-1:0] long_val,
                             input int n_items, input int span, input int poll_pct);
        logic [LEVEL_W-1:0] lv;
        logic [FUNC_W-1:0]  f;
        write_reg(CFG_SHORT_THR, short_val);
        write_reg(CFG_LONG_THR, long_val);
        for (int i = 0; i < n_items; i++)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (hold_left[k] <= 0)
                begin
                    held[k]      = ~held[k];
                    hold_left[k] = $urandom_range(1, span);
                end
            end
            f  = ($urandom_range(0, 99) < poll_pct) ? FUNC_POLL : FUNC_TICK;
            lv = ($urandom_range(0, 99) < 8) ? LEVEL_W'($urandom()) : held;
            send_word(f, lv);
            if (f == FUNC_TICK)
                for (int k = 0; k < NUM_KEYS; k++)
                    hold_left[k]--;
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_threshold(cfg_ch.index, cfg_ch.data);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.key_code, out_ch.press_kind);
            if (in_ch.valid && in_ch.ready)
                sb.note_word(in_ch.func, in_ch.key_levels);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_asks != stall_done)
            begin
                // hold off long enough for the block to back up its input
                out_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_done++;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_TICK;
        in_ch.key_levels <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_SHORT_THR;
        cfg_ch.data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // thresholds at their reset values
        repeat (6) send_word(FUNC_TICK, '1);
        send_word(FUNC_POLL, '0);
        drain();

        // tight thresholds: long set back goes negative
        write_reg(CFG_SHORT_THR, 15'd0);
        write_reg(CFG_LONG_THR, 15'd30);
        send_word(FUNC_POLL, '0);
        send_word(FUNC_TICK, '1);
        send_word(FUNC_POLL, '0);
        repeat (3) send_word(FUNC_TICK, '1);
        send_word(FUNC_POLL, '1);
        send_word(FUNC_POLL, '0);
        send_word(FUNC_POLL, '0);
        send_word(FUNC_TICK, 6'h10);
        send_word(FUNC_TICK, 6'h20);
        send_word(FUNC_TICK, 6'h2A);
        repeat (3) send_word(FUNC_POLL, 6'h15);
        repeat (4) send_word(FUNC_TICK, 6'h01);
        send_word(FUNC_POLL, 6'h01);
        send_word(FUNC_POLL, 6'h00);
        drain();

        stall_asks = 1;
        run_phase(15'd0, 15'd500, 250, 120, 20);
        run_phase(SHORT_THR_RESET, LONG_THR_RESET, 300, 220, 15);
        // repeat leaves the counter between the thresholds: release reports short too
        run_phase(15'd60, 15'd600, 300, 150, 20);
        run_phase(15'd0, 15'd0, 150, 8, 40);
        run_phase(15'd30, 15'd200, 250, 60, 25);

        // thresholds near the top of the counter range
        write_reg(CFG_SHORT_THR, 15'd30000);
        write_reg(CFG_LONG_THR, 15'd29999);
        repeat (7) send_word(FUNC_POLL, '1);
        drain();
        run_phase(15'd30000, 15'd29999, 100, 20, 25);

        idle_on = 1'b0;
        run_phase(THR_W'($urandom_range(0, 200)), THR_W'($urandom_range(0, 800)), 250, 100, 25);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
